/* rtl/lrs_pkg.sv */
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and constants for the linear resampler.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int STEP_W     = 23;
    localparam int CNT_CFG_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MAX_RUN    = 64;
    localparam int RUN_W      = $clog2(MAX_RUN + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MONO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT  = 3'd3;

    localparam logic [STEP_W-1:0]    STEP_RESET = 23'd65536;
    localparam logic [CNT_CFG_W-1:0] CNT_RESET  = 24'd1;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic                  mono;
        logic [STEP_W-1:0]     step;
        logic [CNT_CFG_W-1:0]  src_count;
        logic [CNT_CFG_W-1:0]  out_count;
    } t_cfg;

    // Pair of source frames an output is interpolated between
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] older_l;
        logic signed [SAMPLE_W-1:0] older_r;
        logic signed [SAMPLE_W-1:0] newest_l;
        logic signed [SAMPLE_W-1:0] newest_r;
    } t_pair;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last_of_run;
        logic                       end_of_clip;
    } t_result;

endpackage

/* rtl/lrs_fifo.sv */
// ----------------------------------------------------------------------------
// lrs_fifo
// Small register FIFO with occupancy count; head word shown combinationally.
// ----------------------------------------------------------------------------
module lrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_wdata,
    input  logic                           i_pop,
    output logic [WIDTH-1:0]               o_rdata,
    output logic                           o_full,
    output logic                           o_empty,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

/* rtl/lrs_front.sv */
// ----------------------------------------------------------------------------
// lrs_front
// Frame intake: counts source frames, keeps the last pair, and makes a job
// for the output sequencer per accepted frame but a longer clip's first.
// ----------------------------------------------------------------------------
module lrs_front #(
    parameter int COUNT_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lrs_pkg::t_cfg                        i_cfg,
    input  logic                                 i_push,
    input  logic signed [lrs_pkg::SAMPLE_W-1:0]  i_left,
    input  logic signed [lrs_pkg::SAMPLE_W-1:0]  i_right,
    input  logic                                 i_job_full,
    output logic                                 o_full,
    output logic                                 o_job_push,
    output lrs_pkg::t_pair                       o_job_pair,
    output logic [COUNT_BITS-1:0]                o_job_k,
    output logic                                 o_job_final
);
    import lrs_pkg::*;

    logic [COUNT_BITS-1:0]       r_frames;
    logic signed [SAMPLE_W-1:0]  r_older_l, r_older_r, r_prev_l, r_prev_r;
    logic [COUNT_BITS-1:0]       src_cnt;
    logic signed [SAMPLE_W-1:0]  right_in;
    logic                        accept, in_clip, first_frame, final_f;

    assign o_full = i_job_full;

    always_comb begin
        src_cnt = COUNT_BITS'(i_cfg.src_count);
        if (src_cnt == '0) begin
            src_cnt = COUNT_BITS'(1);
        end
        accept      = i_push && !i_job_full;
        in_clip     = (r_frames < src_cnt);
        first_frame = in_clip && (r_frames == '0);
        right_in    = i_cfg.mono ? i_left : i_right;
        final_f     = in_clip ? (r_frames == src_cnt - 1'b1) : 1'b1;

        if (in_clip) begin
            o_job_k             = r_frames;
            o_job_pair.newest_l = i_left;
            o_job_pair.newest_r = right_in;
            o_job_pair.older_l  = first_frame ? i_left : r_prev_l;
            o_job_pair.older_r  = first_frame ? right_in : r_prev_r;
        end else begin
            // past the clip: samples are dropped, the kept pair is reused
            o_job_k             = src_cnt - 1'b1;
            o_job_pair.newest_l = r_prev_l;
            o_job_pair.newest_r = r_prev_r;
            o_job_pair.older_l  = r_older_l;
            o_job_pair.older_r  = r_older_r;
        end
        o_job_final = final_f;
        o_job_push  = accept && !(first_frame && !final_f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames  <= '0;
            r_older_l <= '0;
            r_older_r <= '0;
            r_prev_l  <= '0;
            r_prev_r  <= '0;
        end else if (accept && in_clip) begin
            r_frames  <= r_frames + 1'b1;
            r_older_l <= o_job_pair.older_l;
            r_older_r <= o_job_pair.older_r;
            r_prev_l  <= o_job_pair.newest_l;
            r_prev_r  <= o_job_pair.newest_r;
        end
    end

endmodule

/* rtl/lrs_back.sv */
// ----------------------------------------------------------------------------
// lrs_back
// Output sequencer and interpolation pipeline: walks the position
// accumulator for one job, one output per cycle while the result queue and
// pipe have room, through a subtract/clamp, multiply and round/saturate pipe.
// ----------------------------------------------------------------------------
module lrs_back #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 24,
    parameter int RES_DEPTH  = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lrs_pkg::t_cfg                        i_cfg,
    input  logic                                 i_job_empty,
    input  lrs_pkg::t_pair                       i_job_pair,
    input  logic [COUNT_BITS-1:0]                i_job_k,
    input  logic                                 i_job_final,
    output logic                                 o_job_pop,
    input  logic [$clog2(RES_DEPTH+1)-1:0]       i_res_count,
    output logic                                 o_res_push,
    output lrs_pkg::t_result                     o_res
);
    import lrs_pkg::*;

    localparam int POS_BITS = COUNT_BITS + FRAC_BITS;
    localparam int FRAC_W   = FRAC_BITS + DIFF_W;
    localparam int PROD_W   = FRAC_W + DIFF_W;
    localparam int Q_W      = PROD_W - FRAC_BITS;
    localparam int HW       = COUNT_BITS + DIFF_W + 1;
    localparam int RC_W     = $clog2(RES_DEPTH + 1) + 1;

    localparam logic signed [HW-1:0]     HI_MAX   = HW'((1 << (DIFF_W - 1)) - 1);
    localparam logic signed [HW-1:0]     HI_MIN   = HW'(-(1 << (DIFF_W - 1)));
    localparam logic signed [FRAC_W-1:0] FRAC_MAX = {1'b0, {(FRAC_W-1){1'b1}}};
    localparam logic signed [FRAC_W-1:0] FRAC_MIN = {1'b1, {(FRAC_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] HALF     =
        {{(PROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [Q_W:0]      R_MAX    = (Q_W+1)'(SAT_MAX);
    localparam logic signed [Q_W:0]      R_MIN    = (Q_W+1)'(SAT_MIN);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Round half up, add to the older sample, saturate
    function automatic logic signed [SAMPLE_W-1:0] finish(
        input logic signed [PROD_W-1:0]   prod,
        input logic signed [SAMPLE_W-1:0] a
    );
        logic signed [PROD_W-1:0] p;
        logic signed [Q_W-1:0]    q;
        logic signed [Q_W:0]      r;
        p = prod + HALF;
        q = $signed(p[PROD_W-1:FRAC_BITS]);
        r = $signed((Q_W+1)'(a)) + $signed((Q_W+1)'(q));
        if (r > R_MAX) begin
            finish = SAT_MAX;
        end else if (r < R_MIN) begin
            finish = SAT_MIN;
        end else begin
            finish = r[SAMPLE_W-1:0];
        end
    endfunction

    // sequencer state
    logic                        r_state, n_state;
    logic [POS_BITS-1:0]         r_pos, n_pos;
    logic [COUNT_BITS-1:0]       r_emitted, n_emitted;
    logic [RUN_W-1:0]            r_run, n_run;
    logic [COUNT_BITS-1:0]       r_k, r_kb;
    logic                        r_final;
    logic signed [SAMPLE_W-1:0]  r_a_l, r_a_r;
    logic signed [DIFF_W-1:0]    r_d_l, r_d_r;

    // pipeline stage 1: fraction
    logic                        r_s1_v;
    logic signed [FRAC_W-1:0]    r_s1_frac;
    logic signed [SAMPLE_W-1:0]  r_s1_a_l, r_s1_a_r;
    logic signed [DIFF_W-1:0]    r_s1_d_l, r_s1_d_r;
    logic                        r_s1_last, r_s1_eoc;

    // pipeline stage 2: products
    logic                        r_s2_v;
    logic signed [PROD_W-1:0]    r_s2_prod_l, r_s2_prod_r;
    logic signed [SAMPLE_W-1:0]  r_s2_a_l, r_s2_a_r;
    logic                        r_s2_last, r_s2_eoc;

    logic [COUNT_BITS-1:0]       out_cnt, pos_hi, pos_next_hi, emit_next;
    logic [POS_BITS-1:0]         pos_next;
    logic [RUN_W-1:0]            run_next;
    logic signed [HW-1:0]        hi_diff;
    logic signed [FRAC_W-1:0]    frac;
    logic                        credit, go, more, issue;

    always_comb begin
        out_cnt = COUNT_BITS'(i_cfg.out_count);
        if (out_cnt == '0) begin
            out_cnt = COUNT_BITS'(1);
        end
        pos_hi      = r_pos[POS_BITS-1:FRAC_BITS];
        pos_next    = r_pos + POS_BITS'(i_cfg.step);
        pos_next_hi = pos_next[POS_BITS-1:FRAC_BITS];
        emit_next   = r_emitted + 1'b1;
        run_next    = r_run + 1'b1;

        credit = (RC_W'(i_res_count) + RC_W'(r_s1_v) + RC_W'(r_s2_v)) < RC_W'(RES_DEPTH);
        go     = (r_run < RUN_W'(MAX_RUN)) && (r_emitted < out_cnt)
                 && (r_final || (pos_hi < r_k));
        // look one output ahead to flag the end of this run
        more   = (run_next < RUN_W'(MAX_RUN)) && (emit_next < out_cnt)
                 && (r_final || (pos_next_hi < r_k));
        issue  = (r_state == ST_RUN) && credit && go;

        hi_diff = $signed(HW'(pos_hi)) - $signed(HW'(r_kb));
        if (hi_diff > HI_MAX) begin
            frac = FRAC_MAX;
        end else if (hi_diff < HI_MIN) begin
            frac = FRAC_MIN;
        end else begin
            frac = {hi_diff[DIFF_W-1:0], r_pos[FRAC_BITS-1:0]};
        end
    end

    assign o_job_pop = (r_state == ST_IDLE) && !i_job_empty;

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_emitted = r_emitted;
        n_run     = r_run;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_job_empty) begin
                    n_state = ST_RUN;
                    n_run   = '0;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    n_pos     = pos_next;
                    n_emitted = emit_next;
                    n_run     = run_next;
                    if (!more) begin
                        n_state = ST_IDLE;
                    end
                end else if (credit) begin
                    // nothing due for this job
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_emitted <= '0;
            r_run     <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_emitted <= n_emitted;
            r_run     <= n_run;
            r_s1_v    <= issue;
            r_s2_v    <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_k     <= i_job_k;
            r_kb    <= (i_job_k == '0) ? '0 : i_job_k - 1'b1;
            r_final <= i_job_final;
            r_a_l   <= i_job_pair.older_l;
            r_a_r   <= i_job_pair.older_r;
            r_d_l   <= DIFF_W'(i_job_pair.newest_l) - DIFF_W'(i_job_pair.older_l);
            r_d_r   <= DIFF_W'(i_job_pair.newest_r) - DIFF_W'(i_job_pair.older_r);
        end
        if (issue) begin
            r_s1_frac <= frac;
            r_s1_a_l  <= r_a_l;
            r_s1_a_r  <= r_a_r;
            r_s1_d_l  <= r_d_l;
            r_s1_d_r  <= r_d_r;
            r_s1_last <= !more;
            r_s1_eoc  <= (emit_next == out_cnt);
        end
        r_s2_prod_l <= r_s1_d_l * r_s1_frac;
        r_s2_prod_r <= r_s1_d_r * r_s1_frac;
        r_s2_a_l    <= r_s1_a_l;
        r_s2_a_r    <= r_s1_a_r;
        r_s2_last   <= r_s1_last;
        r_s2_eoc    <= r_s1_eoc;
    end

    assign o_res_push        = r_s2_v;
    assign o_res.left        = finish(r_s2_prod_l, r_s2_a_l);
    assign o_res.right       = finish(r_s2_prod_r, r_s2_a_r);
    assign o_res.last_of_run = r_s2_last;
    assign o_res.end_of_clip = r_s2_eoc;

endmodule

/* rtl/linear_resampler_stereo_top.sv */
// ----------------------------------------------------------------------------
// linear_resampler_stereo_top
// Streaming linear-interpolation resampler with stereo output.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  -------   ---------  --------------------------  ---------------------------
//  frames    in         push / full                 i_left_sample, i_right_sample
//  results   out        empty / pop                 o_left_out, o_right_out,
//                                                   o_last_of_run, o_end_of_clip
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A frame is taken while the two-entry job queue has room.
// The sequencer loads a job, then issues one output per cycle while the
// result queue and pipe have room (up to 64 per frame); each result passes
// through the stage 1 and stage 2 registers into the four-entry result queue.
// The first frame of a longer clip makes no job. Reset clears counters,
// position, kept samples and queues, and returns configuration to defaults.
// A stalled pop holds issue once the result queue and pipe are full.
// ----------------------------------------------------------------------------
module linear_resampler_stereo_top #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [lrs_pkg::SAMPLE_W-1:0]    i_left_sample,
    input  logic signed [lrs_pkg::SAMPLE_W-1:0]    i_right_sample,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [lrs_pkg::SAMPLE_W-1:0]    o_left_out,
    output logic signed [lrs_pkg::SAMPLE_W-1:0]    o_right_out,
    output logic                                   o_last_of_run,
    output logic                                   o_end_of_clip,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [lrs_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import lrs_pkg::*;

    localparam int JOB_DEPTH = 2;
    localparam int RES_DEPTH = 4;
    localparam int JOB_W     = $bits(t_pair) + COUNT_BITS + 1;
    localparam int RES_W     = $bits(t_result);
    localparam int JOB_CW    = $clog2(JOB_DEPTH + 1);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    t_cfg                   r_cfg;

    logic                   job_push, job_pop, job_full, job_empty;
    t_pair                  job_pair_in, job_pair_out;
    logic [COUNT_BITS-1:0]  job_k_in, job_k_out;
    logic                   job_final_in, job_final_out;
    logic [JOB_W-1:0]       job_rdata;
    logic [JOB_CW-1:0]      job_count;

    logic                   res_push;
    t_result                res_in, res_head;
    logic [RES_W-1:0]       res_rdata;
    logic [RES_CW-1:0]      res_count;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mono      <= 1'b0;
            r_cfg.step      <= STEP_RESET;
            r_cfg.src_count <= CNT_RESET;
            r_cfg.out_count <= CNT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MONO: r_cfg.mono      <= i_cfg_data[0];
                CFG_STEP: r_cfg.step      <= i_cfg_data[STEP_W-1:0];
                CFG_SRC:  r_cfg.src_count <= i_cfg_data[CNT_CFG_W-1:0];
                CFG_OUT:  r_cfg.out_count <= i_cfg_data[CNT_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lrs_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_left      (i_left_sample),
        .i_right     (i_right_sample),
        .i_job_full  (job_full),
        .o_full      (full),
        .o_job_push  (job_push),
        .o_job_pair  (job_pair_in),
        .o_job_k     (job_k_in),
        .o_job_final (job_final_in)
    );

    lrs_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_wdata ({job_pair_in, job_k_in, job_final_in}),
        .i_pop   (job_pop),
        .o_rdata (job_rdata),
        .o_full  (job_full),
        .o_empty (job_empty),
        .o_count (job_count)
    );

    assign job_pair_out  = t_pair'(job_rdata[JOB_W-1 -: $bits(t_pair)]);
    assign job_k_out     = job_rdata[COUNT_BITS:1];
    assign job_final_out = job_rdata[0];

    lrs_back #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS),
        .RES_DEPTH  (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (job_empty || (job_count == '0)),
        .i_job_pair  (job_pair_out),
        .i_job_k     (job_k_out),
        .i_job_final (job_final_out),
        .o_job_pop   (job_pop),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    lrs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_full  (),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign res_head      = t_result'(res_rdata);
    assign o_left_out    = res_head.left;
    assign o_right_out   = res_head.right;
    assign o_last_of_run = res_head.last_of_run;
    assign o_end_of_clip = res_head.end_of_clip;

endmodule

/* rtl/lrs_checker.sv */
// ----------------------------------------------------------------------------
// lrs_checker
// Port-level checks for the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module lrs_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 full,
    input logic                                 empty,
    input logic                                 pop,
    input logic signed [lrs_pkg::SAMPLE_W-1:0]  o_left_out,
    input logic signed [lrs_pkg::SAMPLE_W-1:0]  o_right_out,
    input logic                                 o_last_of_run,
    input logic                                 o_end_of_clip
);
    import lrs_pkg::*;

    // reset drains the result queue
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // reset frees the job queue
    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input still full after reset");

    // a waiting result beat is neither lost nor changed
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable({o_left_out, o_right_out,
                                                  o_last_of_run, o_end_of_clip})))
        else $error("waiting result changed without pop");

    // the clip's final output always closes its run
    a_eoc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_end_of_clip) |-> o_last_of_run)
        else $error("end_of_clip without last_of_run");

endmodule

bind linear_resampler_stereo_top lrs_checker u_lrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_left_out    (o_left_out),
    .o_right_out   (o_right_out),
    .o_last_of_run (o_last_of_run),
    .o_end_of_clip (o_end_of_clip)
);
